// File: rtl/roll_reference_model_pid_ff_core_macros.svh
// Assertion macros shared by the roll loop RTL.
`ifndef ROLL_REFERENCE_MODEL_PID_FF_CORE_MACROS_SVH
`define ROLL_REFERENCE_MODEL_PID_FF_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RRM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("roll loop assertion failed");

// Next-cycle implication, checked out of reset.
`define RRM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("roll loop assertion failed");

`endif

// File: rtl/rrm_pkg.sv
// Shared types and constants of the roll loop.
package rrm_pkg;

  localparam int unsigned AddrW = 5;

  localparam logic [2:0] RegAttGain  = 3'd0;
  localparam logic [2:0] RegRateGain = 3'd1;
  localparam logic [2:0] RegIntGain  = 3'd2;
  localparam logic [2:0] RegFfaInit  = 3'd3;
  localparam logic [2:0] RegFfdInit  = 3'd4;
  localparam logic [2:0] RegMixGain  = 3'd5;
  localparam logic [2:0] RegIntLimit = 3'd6;
  localparam logic [2:0] RegAdaptEn  = 3'd7;

  // round(x/60) = floor((2x + 60)/120); bias numerator by 120*2^14 to keep it positive,
  // then floor(m/120) = (m * ceil(2^30/120)) >> 30 exactly for m < 2^22.
  localparam logic signed [32:0] DivAdd   = 33'sd1966140;
  localparam logic signed [32:0] DivRecip = 33'sd8947849;
  localparam logic signed [22:0] DivBias  = 23'sd16384;
  localparam int unsigned        DivShift = 30;

  localparam logic signed [32:0] KffaStep = 33'sd1377;
  localparam logic signed [32:0] KffdStep = 33'sd17211;
  localparam int unsigned        StepFracBits = 20;

  typedef struct packed {
    logic signed [31:0] att_gain;
    logic signed [31:0] rate_gain;
    logic signed [31:0] int_gain;
    logic signed [31:0] mix_gain;
    logic [14:0]        int_limit;
    logic               adapt_en;
    logic               ffa_load;
    logic               ffd_load;
    logic signed [31:0] load_val;
  } cfg_t;

endpackage

// File: rtl/rrm_mul.sv
// Shared signed multiplier with registered product.
module rrm_mul (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] prod_o
);
  logic signed [65:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;
endmodule

// File: rtl/rrm_cfg.sv
// APB register file of the roll loop.
module rrm_cfg (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [rrm_pkg::AddrW-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output rrm_pkg::cfg_t           cfg_o
);
  import rrm_pkg::*;

  logic signed [31:0] att_q, rg_q, ig_q, ffa_q, ffd_q, mix_q;
  logic [14:0]        lim_q;
  logic               adapt_q;
  logic               wr;
  logic [2:0]         idx;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_q   <= '0;
      rg_q    <= '0;
      ig_q    <= '0;
      ffa_q   <= '0;
      ffd_q   <= '0;
      mix_q   <= '0;
      lim_q   <= '0;
      adapt_q <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        RegAttGain:  att_q   <= pwdata;
        RegRateGain: rg_q    <= pwdata;
        RegIntGain:  ig_q    <= pwdata;
        RegFfaInit:  ffa_q   <= pwdata;
        RegFfdInit:  ffd_q   <= pwdata;
        RegMixGain:  mix_q   <= pwdata;
        RegIntLimit: lim_q   <= pwdata[14:0];
        RegAdaptEn:  adapt_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegAttGain:  prdata = att_q;
      RegRateGain: prdata = rg_q;
      RegIntGain:  prdata = ig_q;
      RegFfaInit:  prdata = ffa_q;
      RegFfdInit:  prdata = ffd_q;
      RegMixGain:  prdata = mix_q;
      RegIntLimit: prdata = {17'b0, lim_q};
      RegAdaptEn:  prdata = {31'b0, adapt_q};
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.att_gain  = att_q;
    cfg_o.rate_gain = rg_q;
    cfg_o.int_gain  = ig_q;
    cfg_o.mix_gain  = mix_q;
    cfg_o.int_limit = lim_q;
    cfg_o.adapt_en  = adapt_q;
    cfg_o.ffa_load  = wr && (idx == RegFfaInit);
    cfg_o.ffd_load  = wr && (idx == RegFfdInit);
    cfg_o.load_val  = pwdata;
  end
endmodule

// File: rtl/roll_reference_model_pid_ff_core.sv
// Roll attitude loop top level: reference trajectory, adaptive feedforward, PID, mixing.
//
//   channel   direction  handshake                 payload
//   in        request    in_valid_i / in_ready_o   roll_target, roll_measured,
//                                                  roll_rate_measured, throttle, manual_mode
//   out       result     out_valid_o / out_ready_i aileron_command
//   cfg       APB write  psel & penable & pwrite   paddr / pwdata, 8 registers at 4*i
//
// A request runs through more sequencer steps with adaptation on than with it off;
// every product goes through one registered 33x33 multiplier, in an operand select
// step followed by a write back step.
// Reset clears the reference trajectory, integrator, feedforward gains and last feedback.
// in_ready_o is high only while the sequencer is idle; a finished command waits in
// the output register while the next request is accepted and worked on, and the
// sequencer holds in its final step if that register is still full.
module roll_reference_model_pid_ff_core #(
  parameter int FULL_SCALE      = 9600,
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [15:0]        roll_target_i,
  input  logic signed [15:0]        roll_measured_i,
  input  logic signed [15:0]        roll_rate_measured_i,
  input  logic [13:0]               throttle_i,
  input  logic                      manual_mode_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [14:0]        aileron_command_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rrm_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import rrm_pkg::*;
`include "roll_reference_model_pid_ff_core_macros.svh"

  localparam int F = ANGLE_FRAC_BITS;
  localparam longint unsigned RateLimU =
    ((64'd1745329252 << F) + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned AccLimU =
    ((64'd8726646260 << (F - 3)) + 64'd500000000) / 64'd1000000000;
  localparam logic signed [18:0] RateLim = 19'(RateLimU);
  localparam logic signed [18:0] AccLim  = 19'(AccLimU);
  localparam int ShA = StepFracBits + F - 3;
  localparam int ShD = StepFracBits + F;
  localparam logic signed [65:0] FsPos = 66'(FULL_SCALE);

  // Sequencer steps.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ANG  = 4'd1;
  localparam logic [3:0] ST_RATE = 4'd2;
  localparam logic [3:0] ST_ACC  = 4'd3;
  localparam logic [3:0] ST_ADA1 = 4'd4;
  localparam logic [3:0] ST_ADA2 = 4'd5;
  localparam logic [3:0] ST_ADD1 = 4'd6;
  localparam logic [3:0] ST_ADD2 = 4'd7;
  localparam logic [3:0] ST_INT  = 4'd8;
  localparam logic [3:0] ST_T1   = 4'd9;
  localparam logic [3:0] ST_T2   = 4'd10;
  localparam logic [3:0] ST_T3   = 4'd11;
  localparam logic [3:0] ST_T4   = 4'd12;
  localparam logic [3:0] ST_T5   = 4'd13;
  localparam logic [3:0] ST_T6   = 4'd14;
  localparam logic [3:0] ST_OUT  = 4'd15;

  cfg_t cfg;

  rrm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [3:0] state_q;
  logic       ph_q;
  logic       out_valid_q;
  logic signed [14:0] cmd_q;

  // Loop state.
  logic signed [15:0] ref_angle_q, ref_rate_q, ref_accel_q, integ_q;
  logic signed [31:0] ffa_q, ffd_q, lf_q;

  // Request and scratch registers.
  logic signed [15:0] tgt_q, phi_q, rmeas_q;
  logic [13:0]        thr_q;
  logic signed [17:0] urate_q;
  logic signed [16:0] err_q;
  logic signed [23:0] derr_q;
  logic signed [32:0] tmp_q;
  logic signed [65:0] sum_q;
  logic signed [49:0] fb_q;

  logic               accept;
  logic               out_free;
  logic signed [32:0] mul_a, mul_b, div_src;
  logic signed [65:0] prod;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Operand select for the shared multiplier.
  always_comb begin
    case (state_q)
      ST_RATE: div_src = 33'(ref_accel_q) <<< 3;
      ST_INT:  div_src = 33'(err_q);
      default: div_src = 33'(ref_rate_q);
    endcase
  end

  always_comb begin
    case (state_q)
      ST_ADA1: begin mul_a = 33'(ref_accel_q);        mul_b = KffaStep;        end
      ST_ADA2: begin mul_a = tmp_q;                   mul_b = 33'(lf_q);       end
      ST_ADD1: begin mul_a = 33'(ref_rate_q);         mul_b = KffdStep;        end
      ST_ADD2: begin mul_a = tmp_q;                   mul_b = 33'(lf_q);       end
      ST_T1:   begin mul_a = 33'(ref_accel_q) <<< 3;  mul_b = 33'(ffa_q);      end
      ST_T2:   begin mul_a = 33'(ref_rate_q);         mul_b = 33'(ffd_q);      end
      ST_T3:   begin mul_a = 33'(err_q);              mul_b = 33'(cfg.att_gain);  end
      ST_T4:   begin mul_a = 33'(derr_q);             mul_b = 33'(cfg.rate_gain); end
      ST_T5:   begin mul_a = 33'(integ_q);            mul_b = 33'(cfg.int_gain);  end
      ST_T6:   begin mul_a = {19'b0, thr_q};          mul_b = 33'(cfg.mix_gain);  end
      default: begin mul_a = (div_src <<< 1) + DivAdd; mul_b = DivRecip;       end
    endcase
  end

  rrm_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (!ph_q),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Quotient of the divide-by-60 trick.
  logic signed [22:0] q_div;
  assign q_div = $signed({1'b0, prod[DivShift+21:DivShift]}) - DivBias;

  logic signed [23:0] ang_sum, int_sum, int_lim;
  logic signed [15:0] ang_c;
  assign ang_sum = 24'(ref_angle_q) + 24'(q_div);
  assign ang_c   = (ang_sum > 24'sd32767) ? 16'sh7fff :
                   (ang_sum < -24'sd32768) ? 16'sh8000 : 16'(ang_sum);
  assign int_lim = $signed({9'b0, cfg.int_limit});
  assign int_sum = 24'(integ_q) + 24'(q_div);

  // Reference acceleration, rate bound and errors.
  logic signed [16:0] d_ang, err_c, rerr;
  logic signed [23:0] acc_x, derr_c;
  logic signed [18:0] acc0, acc1, acc_c, urate_x, rate_c;
  always_comb begin
    d_ang   = 17'(tgt_q) - 17'(ref_angle_q);
    acc_x   = (24'(d_ang) <<< 4) + (24'(d_ang) <<< 3) + 24'(d_ang)
            - ((24'(urate_q) <<< 4) + 24'(urate_q));
    acc0    = 19'((acc_x + 24'sd16) >>> 5);
    acc1    = (acc0 > AccLim) ? AccLim : ((acc0 < -AccLim) ? -AccLim : acc0);
    urate_x = 19'(urate_q);
    rate_c  = urate_x;
    acc_c   = acc1;
    if (urate_x > RateLim) begin
      rate_c = RateLim;
      if (acc1 > 19'sd0) acc_c = '0;
    end else if (urate_x < -RateLim) begin
      rate_c = -RateLim;
      if (acc1 < 19'sd0) acc_c = '0;
    end
    err_c  = 17'(phi_q) - 17'(ref_angle_q);
    rerr   = 17'(rmeas_q) - 17'(rate_c);
    derr_c = (24'(rerr) <<< 6) - (24'(rerr) <<< 2);
  end

  // Gain step: subtract, saturate, keep at or below zero.
  function automatic logic signed [31:0] adapt_gain(logic signed [31:0] g,
                                                    logic signed [65:0] dlt);
    logic signed [66:0] diff;
    diff = 67'(g) - 67'(dlt);
    if (diff > 67'sd0) return 32'sd0;
    else if (diff < -(67'sd2147483648)) return 32'sh80000000;
    else return 32'(diff);
  endfunction

  logic signed [65:0] da, dd, cmd_r;
  logic signed [49:0] lf_r;
  assign da    = (prod + (66'sd1 <<< (ShA - 1))) >>> ShA;
  assign dd    = (prod + (66'sd1 <<< (ShD - 1))) >>> ShD;
  assign cmd_r = (sum_q + (66'sd1 <<< (15 + F))) >>> (16 + F);
  assign lf_r  = (fb_q + (50'sd1 <<< (F - 1))) >>> F;

  // Sequencer and loop state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= 1'b0;
      out_valid_q <= 1'b0;
      ref_angle_q <= '0;
      ref_rate_q  <= '0;
      ref_accel_q <= '0;
      integ_q     <= '0;
      ffa_q       <= '0;
      ffd_q       <= '0;
      lf_q        <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cfg.ffa_load) ffa_q <= cfg.load_val;
      if (cfg.ffd_load) ffd_q <= cfg.load_val;
      unique case (state_q)
        ST_IDLE: begin
          ph_q <= 1'b0;
          if (accept) begin
            state_q <= ST_ANG;
            if (manual_mode_i) integ_q <= '0;
          end
        end
        ST_ACC: begin
          ref_rate_q  <= 16'(rate_c);
          ref_accel_q <= 16'(acc_c);
          state_q     <= cfg.adapt_en ? ST_ADA1 : ST_INT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            lf_q <= (lf_r > 50'sd2147483647) ? 32'sh7fffffff :
                    (lf_r < -(50'sd2147483648)) ? 32'sh80000000 : 32'(lf_r);
            state_q <= ST_IDLE;
          end
        end
        default: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            case (state_q)
              ST_ANG:  begin ref_angle_q <= ang_c; state_q <= ST_RATE; end
              ST_RATE: state_q <= ST_ACC;
              ST_ADA1: state_q <= ST_ADA2;
              ST_ADA2: begin ffa_q <= adapt_gain(ffa_q, da); state_q <= ST_ADD1; end
              ST_ADD1: state_q <= ST_ADD2;
              ST_ADD2: begin ffd_q <= adapt_gain(ffd_q, dd); state_q <= ST_INT; end
              ST_INT: begin
                integ_q <= (int_sum > int_lim) ? 16'(int_lim) :
                           (int_sum < -int_lim) ? 16'(-int_lim) : 16'(int_sum);
                state_q <= ST_T1;
              end
              ST_T6:   state_q <= ST_OUT;
              default: state_q <= state_q + 4'd1;
            endcase
          end
        end
      endcase
    end
  end

  // Request capture and scratch datapath.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tgt_q   <= roll_target_i;
      phi_q   <= roll_measured_i;
      rmeas_q <= roll_rate_measured_i;
      thr_q   <= throttle_i;
    end
    if (state_q == ST_ACC) begin
      err_q  <= err_c;
      derr_q <= derr_c;
    end
    if (state_q == ST_OUT && out_free) begin
      cmd_q <= (cmd_r > FsPos) ? 15'(FULL_SCALE) :
               (cmd_r < -FsPos) ? 15'(-FULL_SCALE) : 15'(cmd_r);
    end
    if (ph_q) begin
      case (state_q)
        ST_RATE: urate_q <= 18'(24'(ref_rate_q) + 24'(q_div));
        ST_ADA1: tmp_q   <= prod[32:0];
        ST_ADD1: tmp_q   <= prod[32:0];
        ST_T1:   sum_q   <= prod;
        ST_T2:   sum_q   <= sum_q + prod;
        ST_T3: begin
          sum_q <= sum_q - prod;
          fb_q  <= 50'(prod);
        end
        ST_T4:   sum_q   <= sum_q - prod;
        ST_T5:   sum_q   <= sum_q - prod;
        ST_T6:   sum_q   <= sum_q + (prod <<< F);
        default: ;
      endcase
    end
  end

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign aileron_command_o = cmd_q;

  `RRM_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, accept, state_q == ST_ANG)
  `RRM_ASSERT_NOW(a_idle_phase, clk_i, rst_ni, state_q == ST_IDLE, !ph_q)
  `RRM_ASSERT_NEXT(a_out_loads, clk_i, rst_ni, state_q == ST_OUT && out_free, out_valid_q)
  `RRM_ASSERT_NOW(a_cmd_range, clk_i, rst_ni, out_valid_q,
                  (32'(cmd_q) <= FULL_SCALE) && (32'(cmd_q) >= -FULL_SCALE))
endmodule
